// ===== rtl/owb_pkg.sv =====
// types and constants shared by the single-wire bus master
package owb_pkg;

	localparam int unsigned CFG_DATA_W  = 16;
	localparam int unsigned CFG_INDEX_W = 3;

	// configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] CFG_RESET_LOW     = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_PRESENCE_WAIT = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_RECOVERY      = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_SLOT          = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_START_LOW     = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] CFG_READ_SAMPLE   = 3'd5;

	// reset values of the timing registers, at a 1 us tick
	localparam logic [15:0] RESET_LOW_DEFAULT     = 16'd662;
	localparam logic [15:0] PRESENCE_WAIT_DEFAULT = 16'd44;
	localparam logic [15:0] RECOVERY_DEFAULT      = 16'd434;
	localparam logic [15:0] SLOT_DEFAULT          = 16'd77;
	localparam logic [7:0]  START_LOW_DEFAULT     = 8'd1;
	localparam logic [7:0]  READ_SAMPLE_DEFAULT   = 8'd1;

	// command codes
	localparam logic [1:0] FUNC_RESET = 2'd0;
	localparam logic [1:0] FUNC_WRITE = 2'd1;
	localparam logic [1:0] FUNC_READ  = 2'd2;

	typedef enum logic [5:0] {
		PH_IDLE      = 6'b000001,
		PH_RST_LOW   = 6'b000010,
		PH_RST_WAIT  = 6'b000100,
		PH_RST_REC   = 6'b001000,
		PH_SLOT_LOW  = 6'b010000,
		PH_SLOT_BODY = 6'b100000
	} owb_phase_t;

	typedef struct packed {
		logic       cmd_valid;
		logic [1:0] func;
		logic [7:0] write_data;
		logic       line_level;
	} owb_in_t;

	typedef struct packed {
		logic       drive_low;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_data;
		logic       presence;
	} owb_out_t;

	typedef struct packed {
		logic [15:0] reset_low_ticks;
		logic [15:0] presence_wait_ticks;
		logic [15:0] recovery_ticks;
		logic [15:0] slot_ticks;
		logic [7:0]  start_low_ticks;
		logic [7:0]  read_sample_ticks;
	} owb_cfg_t;

endpackage

// ===== rtl/owb_seq.sv =====
// bus sequencer: phase, tick timer, bit counter and shift byte, one tick per step
module owb_seq #(
	parameter int unsigned TIMER_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  owb_pkg::owb_in_t  item,
	input  owb_pkg::owb_cfg_t cfg,
	output owb_pkg::owb_out_t res
);
	import owb_pkg::*;

	localparam int unsigned CW = ((TIMER_BITS > 16) ? TIMER_BITS : 16) + 1;

	owb_phase_t            phase_q, eff_phase, phase_n;
	logic [TIMER_BITS-1:0] timer_q, eff_timer, timer_n;
	logic [2:0]            bits_q, eff_bits, bits_n;
	logic [7:0]            shift_q, eff_shift, shift_n;
	logic                  wr_q, eff_wr;
	logic                  presence_q, presence_n;
	logic [7:0]            hold_q, hold_n;

	logic          start;
	logic [15:0]   dur;
	logic [CW-1:0] dur_ext, t_ext, rs_ext;
	logic          last, sample;
	logic          drive, done;

	assign start = (phase_q == PH_IDLE) && item.cmd_valid &&
		((item.func == FUNC_RESET) || (item.func == FUNC_WRITE) ||
		 (item.func == FUNC_READ));

	// a command starts on the tick it arrives, as the first tick of its first phase
	always_comb begin
		if (start) begin
			eff_phase = (item.func == FUNC_RESET) ? PH_RST_LOW : PH_SLOT_LOW;
			eff_timer = '0;
			eff_bits  = '0;
			eff_shift = (item.func == FUNC_WRITE) ? item.write_data : 8'd0;
			eff_wr    = (item.func == FUNC_WRITE);
		end else begin
			eff_phase = phase_q;
			eff_timer = timer_q;
			eff_bits  = bits_q;
			eff_shift = shift_q;
			eff_wr    = wr_q;
		end
	end

	always_comb begin
		unique case (eff_phase)
			PH_RST_LOW:   dur = cfg.reset_low_ticks;
			PH_RST_WAIT:  dur = cfg.presence_wait_ticks;
			PH_RST_REC:   dur = cfg.recovery_ticks;
			PH_SLOT_LOW:  dur = {8'd0, cfg.start_low_ticks};
			PH_SLOT_BODY: dur = cfg.slot_ticks;
			default:      dur = 16'd1;
		endcase
	end

	// zero duration counts as one tick; a full timer ends the phase too
	assign dur_ext = (dur == 16'd0) ? CW'(1) : CW'(dur);
	assign t_ext   = CW'(eff_timer);
	assign rs_ext  = CW'(cfg.read_sample_ticks);
	assign last    = ((t_ext + CW'(1)) >= dur_ext) || (eff_timer == '1);
	assign sample  = (t_ext == rs_ext) || (last && (rs_ext > t_ext));

	always_comb begin
		phase_n    = eff_phase;
		bits_n     = eff_bits;
		shift_n    = eff_shift;
		presence_n = presence_q;
		hold_n     = hold_q;
		drive      = 1'b0;
		done       = 1'b0;
		unique case (eff_phase)
			PH_RST_LOW: begin
				drive = 1'b1;
				if (last) phase_n = PH_RST_WAIT;
			end
			PH_RST_WAIT: begin
				if (last) begin
					presence_n = ~item.line_level;
					phase_n    = PH_RST_REC;
				end
			end
			PH_RST_REC: begin
				if (last) begin
					done    = 1'b1;
					phase_n = PH_IDLE;
				end
			end
			PH_SLOT_LOW: begin
				drive = 1'b1;
				if (last) phase_n = PH_SLOT_BODY;
			end
			PH_SLOT_BODY: begin
				if (eff_wr) begin
					drive = ~eff_shift[eff_bits];
				end else if (sample) begin
					shift_n[eff_bits] = item.line_level;
				end
				if (last) begin
					if (eff_bits == 3'd7) begin
						done    = 1'b1;
						phase_n = PH_IDLE;
						bits_n  = 3'd0;
						if (!eff_wr) hold_n = shift_n;
					end else begin
						bits_n  = eff_bits + 3'd1;
						phase_n = PH_SLOT_LOW;
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign timer_n = last ? '0 : eff_timer + TIMER_BITS'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			timer_q    <= '0;
			bits_q     <= '0;
			shift_q    <= '0;
			wr_q       <= 1'b0;
			presence_q <= 1'b0;
			hold_q     <= '0;
		end else if (step) begin
			phase_q    <= phase_n;
			bits_q     <= bits_n;
			shift_q    <= shift_n;
			wr_q       <= eff_wr;
			presence_q <= presence_n;
			hold_q     <= hold_n;
			if (eff_phase != PH_IDLE) timer_q <= timer_n;
		end
	end

	assign res.drive_low = drive;
	assign res.busy_res  = (eff_phase != PH_IDLE);
	assign res.done_res  = done;
	assign res.read_data = hold_n;
	assign res.presence  = presence_n;

endmodule

// ===== rtl/one_wire_bus_master.sv =====
// single-wire bus master top level: input register, sequencer, result register
//
//  channel | direction | handshake        | payload
//  --------+-----------+------------------+---------------------------
//  in      | into      | in_valid/in_stall   | in_item  (owb_in_t)
//  out     | out of    | out_valid/out_stall | out_item (owb_out_t)
//  cfg     | into      | cfg_we              | cfg_index, cfg_data
//
// every item is one bus tick; its result item is registered when the sequencer steps
// an item is accepted every cycle unless the output stalls; state advances once per item
// a stall on the output backs up into the input register and then into in_stall
// reset clears the handshake and sequencer state and loads the timing registers
module one_wire_bus_master #(
	parameter int unsigned TIMER_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  owb_pkg::owb_in_t                    in_item,
	output logic                                out_valid,
	input  logic                                out_stall,
	output owb_pkg::owb_out_t                   out_item,
	input  logic                                cfg_we,
	input  logic [owb_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [owb_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import owb_pkg::*;

	logic     s1_valid_q;
	owb_in_t  item_s1;
	logic     step;
	logic     out_valid_q;
	owb_out_t out_item_q;
	owb_out_t res;
	owb_cfg_t cfg_q;

	assign step     = s1_valid_q && (!out_valid_q || !out_stall);
	assign in_stall = s1_valid_q && !step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_valid && !in_stall) begin
			s1_valid_q <= 1'b1;
		end else if (step) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) item_s1 <= in_item;
	end

	owb_seq #(
		.TIMER_BITS(TIMER_BITS)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.cfg    (cfg_q),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) out_item_q <= res;
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reset_low_ticks     <= RESET_LOW_DEFAULT;
			cfg_q.presence_wait_ticks <= PRESENCE_WAIT_DEFAULT;
			cfg_q.recovery_ticks      <= RECOVERY_DEFAULT;
			cfg_q.slot_ticks          <= SLOT_DEFAULT;
			cfg_q.start_low_ticks     <= START_LOW_DEFAULT;
			cfg_q.read_sample_ticks   <= READ_SAMPLE_DEFAULT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_RESET_LOW:     cfg_q.reset_low_ticks     <= cfg_data;
				CFG_PRESENCE_WAIT: cfg_q.presence_wait_ticks <= cfg_data;
				CFG_RECOVERY:      cfg_q.recovery_ticks      <= cfg_data;
				CFG_SLOT:          cfg_q.slot_ticks          <= cfg_data;
				CFG_START_LOW:     cfg_q.start_low_ticks     <= cfg_data[7:0];
				CFG_READ_SAMPLE:   cfg_q.read_sample_ticks   <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (s1_valid_q && out_valid_q && out_stall))
		else $error("input stalled without a blocked result");

	a_step_result: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> out_valid_q)
		else $error("processed item left no result");

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_item_q.done_res) |-> out_item_q.busy_res)
		else $error("done without busy");

	a_idle_release: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_item_q.busy_res) |-> !out_item_q.drive_low)
		else $error("line driven while idle");

endmodule
